/* src/quaternion_to_euler_unit_defines.svh */
// Assertion macros for the quaternion to Euler port checker.
`ifndef QUATERNION_TO_EULER_UNIT_DEFINES_SVH
`define QUATERNION_TO_EULER_UNIT_DEFINES_SVH

// check in the same cycle
`define QTE_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("quaternion_to_euler_unit check failed");

// check in the next cycle
`define QTE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("quaternion_to_euler_unit check failed");

`endif

/* src/qte_pkg.sv */
// Types, constants and the arctangent table for the quaternion to Euler unit.
package qte_pkg;

   typedef enum logic [1:0] {
      POLE_NONE  = 2'd0,
      POLE_NORTH = 2'd1,
      POLE_SOUTH = 2'd2
   } pole_type;

   localparam int OPW  = 35;
   localparam int ANGW = 26;

   typedef logic signed [OPW-1:0]  opnd_type;
   typedef logic signed [ANGW-1:0] angle_type;

   localparam int SQRT_STEPS = 32;
   localparam int NORM_STEPS = 6;
   localparam int CORD_PRE   = 2 + NORM_STEPS;

   localparam int POLE_DEN = 1000;
   localparam int POLE_NUM = 499;

   localparam int LIM_REG  = 11520;
   localparam int LIM_POLE = 23040;
   localparam int LIM_ATT  = 5760;

   localparam angle_type DEG90 = angle_type'(90 * 65536);

   typedef struct packed {
      opnd_type hy;
      opnd_type hx;
      opnd_type by;
      opnd_type bx;
      opnd_type test;
      pole_type pole;
   } sqrt_side_type;

   function automatic logic [21:0] atan_q16(input int idx);
      logic [21:0] v;
      case (idx)
         0:       v = 22'd2949120;
         1:       v = 22'd1740967;
         2:       v = 22'd919879;
         3:       v = 22'd466945;
         4:       v = 22'd234379;
         5:       v = 22'd117304;
         6:       v = 22'd58666;
         7:       v = 22'd29335;
         8:       v = 22'd14668;
         9:       v = 22'd7334;
         10:      v = 22'd3667;
         11:      v = 22'd1833;
         12:      v = 22'd917;
         13:      v = 22'd458;
         14:      v = 22'd229;
         15:      v = 22'd115;
         16:      v = 22'd57;
         17:      v = 22'd29;
         18:      v = 22'd14;
         19:      v = 22'd7;
         20:      v = 22'd4;
         21:      v = 22'd2;
         22:      v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

/* src/qte_cordic.sv */
// Pipelined vectoring CORDIC: normalize, quadrant fold, one iteration per stage.
module qte_cordic #(
   parameter int STAGES = 16
) (
   input  logic               clock,
   input  logic               advance,
   input  qte_pkg::opnd_type  y_in,
   input  qte_pkg::opnd_type  x_in,
   output qte_pkg::angle_type angle
);

   localparam int NW = 42;
   localparam int MW = 41;
   localparam int CW = 45;
   localparam int NS = qte_pkg::NORM_STEPS;

   logic signed [NW-1:0] nx_ff [0:NS];
   logic signed [NW-1:0] ny_ff [0:NS];
   logic [MW-1:0]        nm_ff [0:NS];
   logic                 nz_ff [0:NS];

   logic signed [CW-1:0] cx_ff [0:STAGES];
   logic signed [CW-1:0] cy_ff [0:STAGES];
   qte_pkg::angle_type   cz_ff [0:STAGES];
   logic                 cf_ff [0:STAGES];

   logic [qte_pkg::OPW-1:0] ax, ay;

   always_comb begin
      ax = x_in[qte_pkg::OPW-1] ? qte_pkg::OPW'(-x_in) : qte_pkg::OPW'(x_in);
      ay = y_in[qte_pkg::OPW-1] ? qte_pkg::OPW'(-y_in) : qte_pkg::OPW'(y_in);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff[0] <= NW'(x_in);
         ny_ff[0] <= NW'(y_in);
         nm_ff[0] <= MW'(ax | ay);
         nz_ff[0] <= ((ax | ay) == '0);
      end
   end

   for (genvar k = 0; k < NS; k++) begin : g_norm
      localparam int SH = 32 >> k;
      logic shift_up;
      assign shift_up = (nm_ff[k][MW-1 -: SH] == '0);
      always_ff @(posedge clock) begin
         if (advance) begin
            nx_ff[k+1] <= shift_up ? (nx_ff[k] <<< SH) : nx_ff[k];
            ny_ff[k+1] <= shift_up ? (ny_ff[k] <<< SH) : ny_ff[k];
            nm_ff[k+1] <= shift_up ? (nm_ff[k] << SH) : nm_ff[k];
            nz_ff[k+1] <= nz_ff[k];
         end
      end
   end

   logic signed [CW-1:0] px, py;
   assign px = CW'(nx_ff[NS]);
   assign py = CW'(ny_ff[NS]);

   always_ff @(posedge clock) begin
      if (advance) begin
         cf_ff[0] <= nz_ff[NS];
         if (px < 0) begin
            if (py >= 0) begin
               cx_ff[0] <= py;
               cy_ff[0] <= -px;
               cz_ff[0] <= qte_pkg::DEG90;
            end else begin
               cx_ff[0] <= -py;
               cy_ff[0] <= px;
               cz_ff[0] <= -qte_pkg::DEG90;
            end
         end else begin
            cx_ff[0] <= px;
            cy_ff[0] <= py;
            cz_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam qte_pkg::angle_type STEP = qte_pkg::angle_type'(qte_pkg::atan_q16(i));
      logic signed [CW-1:0] dx, dy;
      logic up;
      always_comb begin
         dx = cx_ff[i] >>> i;
         dy = cy_ff[i] >>> i;
         up = !cy_ff[i][CW-1] && (cy_ff[i] != '0);
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            cf_ff[i+1] <= cf_ff[i];
            if (up) begin
               cx_ff[i+1] <= cx_ff[i] + dy;
               cy_ff[i+1] <= cy_ff[i] - dx;
               cz_ff[i+1] <= cz_ff[i] + STEP;
            end else begin
               cx_ff[i+1] <= cx_ff[i] - dy;
               cy_ff[i+1] <= cy_ff[i] + dx;
               cz_ff[i+1] <= cz_ff[i] - STEP;
            end
         end
      end
   end

   assign angle = cf_ff[STAGES] ? '0 : cz_ff[STAGES];

endmodule

/* src/quaternion_to_euler_unit.sv */
// Quaternion to Euler angle converter: products, pole test, square root, three CORDICs.
//
//   channel  direction  handshake             payload
//   req      in         req_valid/req_stall   req_quat_x/y/z/w (Q1.15)
//   rsp      out        rsp_valid/rsp_stall   rsp_bank/heading/attitude_deg, rsp_pole_case
//
// One beat per cycle while the output is not stalled; 3 product stages, 32 root
// stages, 8 + CORDIC_STAGES CORDIC stages, 1 output stage.
// Reset clears only the valid line; data registers are not reset.
// A stalled result at the output freezes the whole pipeline and raises req_stall.
module quaternion_to_euler_unit #(
   parameter int CORDIC_STAGES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   input  logic signed [15:0] req_quat_w,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [14:0] rsp_bank_deg,
   output logic signed [15:0] rsp_heading_deg,
   output logic signed [13:0] rsp_attitude_deg,
   output logic [1:0]         rsp_pole_case
);

   localparam int SQ       = qte_pkg::SQRT_STEPS;
   localparam int CORD_LAT = qte_pkg::CORD_PRE + CORDIC_STAGES;
   localparam int NV       = 4 + SQ + CORD_LAT;
   localparam int OPW      = qte_pkg::OPW;

   logic          vld_ff [0:NV-1];
   logic          advance;

   assign advance   = !(vld_ff[NV-1] && rsp_stall);
   assign req_stall = !advance;
   assign rsp_valid = vld_ff[NV-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NV; k++) vld_ff[k] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < NV; k++) vld_ff[k] <= vld_ff[k-1];
      end
   end

   logic signed [31:0] p_xx_ff, p_yy_ff, p_zz_ff, p_ww_ff;
   logic signed [31:0] p_xy_ff, p_zw_ff, p_yw_ff, p_xz_ff, p_xw_ff, p_yz_ff;
   logic signed [15:0] s1_x_ff, s1_w_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         p_xx_ff <= req_quat_x * req_quat_x;
         p_yy_ff <= req_quat_y * req_quat_y;
         p_zz_ff <= req_quat_z * req_quat_z;
         p_ww_ff <= req_quat_w * req_quat_w;
         p_xy_ff <= req_quat_x * req_quat_y;
         p_zw_ff <= req_quat_z * req_quat_w;
         p_yw_ff <= req_quat_y * req_quat_w;
         p_xz_ff <= req_quat_x * req_quat_z;
         p_xw_ff <= req_quat_x * req_quat_w;
         p_yz_ff <= req_quat_y * req_quat_z;
         s1_x_ff <= req_quat_x;
         s1_w_ff <= req_quat_w;
      end
   end

   logic [32:0]        unit_in, unit_ff;
   logic signed [32:0] test_in, test_ff;
   logic signed [OPW-1:0] dif_in, sum_in;
   qte_pkg::opnd_type  hy_ff, hx_ff, by_ff, bx_ff;
   logic [31:0]        fa_ff, fb_ff;
   logic signed [15:0] s2_x_ff, s2_w_ff;

   always_comb begin
      unit_in = 33'($unsigned(p_xx_ff)) + 33'($unsigned(p_yy_ff))
              + 33'($unsigned(p_zz_ff)) + 33'($unsigned(p_ww_ff));
      test_in = 33'(p_xy_ff) + 33'(p_zw_ff);
      dif_in  = $signed({2'b00, unit_in}) - (OPW'(test_in) <<< 1);
      sum_in  = $signed({2'b00, unit_in}) + (OPW'(test_in) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         unit_ff <= unit_in;
         test_ff <= test_in;
         hy_ff   <= (OPW'(p_yw_ff) - OPW'(p_xz_ff)) <<< 1;
         hx_ff   <= OPW'(p_xx_ff) - OPW'(p_yy_ff) - OPW'(p_zz_ff) + OPW'(p_ww_ff);
         by_ff   <= (OPW'(p_xw_ff) - OPW'(p_yz_ff)) <<< 1;
         bx_ff   <= OPW'(p_yy_ff) - OPW'(p_xx_ff) - OPW'(p_zz_ff) + OPW'(p_ww_ff);
         fa_ff   <= dif_in[32:1];
         fb_ff   <= sum_in[32:1];
         s2_x_ff <= s1_x_ff;
         s2_w_ff <= s1_w_ff;
      end
   end

   logic signed [45:0] t_k, u_k;
   qte_pkg::pole_type  pole_in;

   always_comb begin
      t_k = 46'(test_ff) * 46'(qte_pkg::POLE_DEN);
      u_k = $signed(46'(unit_ff)) * 46'(qte_pkg::POLE_NUM);
      if (t_k > u_k)       pole_in = qte_pkg::POLE_NORTH;
      else if (t_k < -u_k) pole_in = qte_pkg::POLE_SOUTH;
      else                 pole_in = qte_pkg::POLE_NONE;
   end

   logic [63:0]            sq_v_ff    [0:SQ];
   logic [33:0]            sq_rem_ff  [0:SQ];
   logic [31:0]            sq_root_ff [0:SQ];
   qte_pkg::sqrt_side_type sq_side_ff [0:SQ];

   always_ff @(posedge clock) begin
      if (advance) begin
         sq_v_ff[0]         <= 64'(fa_ff) * 64'(fb_ff);
         sq_rem_ff[0]       <= '0;
         sq_root_ff[0]      <= '0;
         sq_side_ff[0].test <= OPW'(test_ff);
         sq_side_ff[0].by   <= by_ff;
         sq_side_ff[0].bx   <= bx_ff;
         sq_side_ff[0].pole <= pole_in;
         if (pole_in != qte_pkg::POLE_NONE) begin
            sq_side_ff[0].hy <= OPW'(s2_x_ff);
            sq_side_ff[0].hx <= OPW'(s2_w_ff);
         end else begin
            sq_side_ff[0].hy <= hy_ff;
            sq_side_ff[0].hx <= hx_ff;
         end
      end
   end

   for (genvar k = 0; k < SQ; k++) begin : g_sqrt
      logic [35:0] rs, tr;
      logic        ge;
      always_comb begin
         rs = {sq_rem_ff[k], sq_v_ff[k][63:62]};
         tr = {2'b00, sq_root_ff[k], 2'b01};
         ge = (rs >= tr);
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            sq_v_ff[k+1]    <= sq_v_ff[k] << 2;
            sq_rem_ff[k+1]  <= ge ? 34'(rs - tr) : 34'(rs);
            sq_root_ff[k+1] <= {sq_root_ff[k][30:0], ge};
            sq_side_ff[k+1] <= sq_side_ff[k];
         end
      end
   end

   qte_pkg::angle_type ang_head, ang_bank, ang_att;

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_head (
      .clock   (clock),
      .advance (advance),
      .y_in    (sq_side_ff[SQ].hy),
      .x_in    (sq_side_ff[SQ].hx),
      .angle   (ang_head)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_bank (
      .clock   (clock),
      .advance (advance),
      .y_in    (sq_side_ff[SQ].by),
      .x_in    (sq_side_ff[SQ].bx),
      .angle   (ang_bank)
   );

   qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_att (
      .clock   (clock),
      .advance (advance),
      .y_in    (sq_side_ff[SQ].test),
      .x_in    (qte_pkg::opnd_type'({3'b000, sq_root_ff[SQ]})),
      .angle   (ang_att)
   );

   qte_pkg::pole_type pole_dl_ff [0:CORD_LAT-1];

   always_ff @(posedge clock) begin
      if (advance) begin
         pole_dl_ff[0] <= sq_side_ff[SQ].pole;
         for (int k = 1; k < CORD_LAT; k++) pole_dl_ff[k] <= pole_dl_ff[k-1];
      end
   end

   function automatic logic signed [15:0] to_64th(input logic signed [27:0] a,
                                                  input logic signed [17:0] lim);
      logic signed [27:0] s;
      logic signed [17:0] r;
      s = a + 28'sd512;
      r = 18'(s >>> 10);
      if (r > lim)       r = lim;
      else if (r < -lim) r = -lim;
      return 16'(r);
   endfunction

   logic signed [27:0] head_x2;
   logic signed [14:0] bank_in, bank_ff;
   logic signed [15:0] head_in, head_ff;
   logic signed [13:0] att_in, att_ff;
   qte_pkg::pole_type  pole_ff;

   always_comb begin
      head_x2 = 28'(ang_head) <<< 1;
      case (pole_dl_ff[CORD_LAT-1])
         qte_pkg::POLE_NORTH: begin
            head_in = to_64th(head_x2, 18'(qte_pkg::LIM_POLE));
            bank_in = '0;
            att_in  = 14'(qte_pkg::LIM_ATT);
         end
         qte_pkg::POLE_SOUTH: begin
            head_in = to_64th(-head_x2, 18'(qte_pkg::LIM_POLE));
            bank_in = '0;
            att_in  = -14'(qte_pkg::LIM_ATT);
         end
         default: begin
            head_in = to_64th(28'(ang_head), 18'(qte_pkg::LIM_REG));
            bank_in = 15'(to_64th(28'(ang_bank), 18'(qte_pkg::LIM_REG)));
            att_in  = 14'(to_64th(28'(ang_att), 18'(qte_pkg::LIM_ATT)));
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         bank_ff <= bank_in;
         head_ff <= head_in;
         att_ff  <= att_in;
         pole_ff <= pole_dl_ff[CORD_LAT-1];
      end
   end

   assign rsp_bank_deg     = bank_ff;
   assign rsp_heading_deg  = head_ff;
   assign rsp_attitude_deg = att_ff;
   assign rsp_pole_case    = pole_ff;

endmodule

/* src/qte_checker.sv */
// Port-level checks for the quaternion to Euler unit, bound to the top level.
`include "quaternion_to_euler_unit_defines.svh"

module qte_port_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [14:0] rsp_bank_deg,
   input logic signed [15:0] rsp_heading_deg,
   input logic signed [13:0] rsp_attitude_deg,
   input logic [1:0]         rsp_pole_case
);

   `QTE_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_heading_deg) && $stable(rsp_bank_deg)
      && $stable(rsp_attitude_deg) && $stable(rsp_pole_case))
   `QTE_ASSERT_NOW(a_stall_src, req_stall, rsp_valid && rsp_stall)
   `QTE_ASSERT_NOW(a_pole_fix, rsp_valid && rsp_pole_case != qte_pkg::POLE_NONE,
      rsp_bank_deg == 15'sd0
      && (rsp_attitude_deg == 14'sd5760 || rsp_attitude_deg == -14'sd5760))
   `QTE_ASSERT_NOW(a_reg_range, rsp_valid && rsp_pole_case == qte_pkg::POLE_NONE,
      rsp_heading_deg <= 16'sd11520 && rsp_heading_deg >= -16'sd11520
      && rsp_bank_deg <= 15'sd11520 && rsp_bank_deg >= -15'sd11520)

endmodule

bind quaternion_to_euler_unit qte_port_checker u_qte_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_bank_deg     (rsp_bank_deg),
   .rsp_heading_deg  (rsp_heading_deg),
   .rsp_attitude_deg (rsp_attitude_deg),
   .rsp_pole_case    (rsp_pole_case)
);
